// ===== hdl/rrcm_pkg.sv =====
package rrcm_pkg;

  // default sizing
  localparam int MAX_SIDE_DEF   = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  // fixed field widths
  localparam int PIX_IN_W   = 16;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int OFFS_W     = 12;
  localparam int POS_W      = 13;
  localparam int MEAN_W     = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 8'd0,
    REG_HEIGHT    = 8'd1,
    REG_FIRST_COL = 8'd2,
    REG_FIRST_ROW = 8'd3
  } reg_idx_t;

  // result kinds
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_COL = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic update;
    logic start_col;
    logic start_row;
    logic advance;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_row;
    logic last_col;
    logic div_done;
  } sts_t;

endpackage

// ===== hdl/rrcm_in_if.sv =====
interface rrcm_in_if;
  logic                              valid;
  logic                              ready;
  logic [rrcm_pkg::PIX_IN_W-1:0]     pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== hdl/rrcm_out_if.sv =====
interface rrcm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [rrcm_pkg::POS_W-1:0]      position;
  logic [rrcm_pkg::MEAN_W-1:0]     mean;
  logic                            last;

  modport source (output valid, output kind, output position, output mean, output last,
                  input ready);
  modport sink   (input valid, input kind, input position, input mean, input last,
                  output ready);
endinterface

// ===== hdl/rrcm_cfg_if.sv =====
interface rrcm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rrcm_pkg::CFG_IDX_W-1:0]      index;
  logic [rrcm_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rrcm_div.sv =====
module rrcm_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(diff) : DEN_W'(shifted);
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/rrcm_dp.sv =====
module rrcm_dp #(
  parameter int MAX_SIDE   = rrcm_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS = rrcm_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rrcm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rrcm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [rrcm_pkg::PIX_IN_W-1:0]   pixel,
  input  rrcm_pkg::cmd_t                  cmd,
  output rrcm_pkg::sts_t                  sts,
  output logic                            res_kind,
  output logic [rrcm_pkg::POS_W-1:0]      res_position,
  output logic [rrcm_pkg::MEAN_W-1:0]     res_mean,
  output logic                            res_last
);

  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int SUM_W  = PIXEL_BITS + CNT_W;

  logic [SIDE_W-1:0]               width_r, height_r;
  logic [rrcm_pkg::OFFS_W-1:0]     first_col_r, first_row_r;
  logic [CNT_W-1:0]                col_cnt_r, row_cnt_r;
  logic [CNT_W-1:0]                col_idx, row_idx;
  logic [SUM_W-1:0]                row_sum_r, csum_r, csum_nxt, rd_data_r;
  logic [PIXEL_BITS-1:0]           px_r;
  logic                            kind_r;
  logic                            last_row, last_col;
  logic [SUM_W-1:0]                column_sums [MAX_SIDE];
  logic                            div_start, div_done;
  logic [SUM_W-1:0]                div_num, div_quo;
  logic [SIDE_W-1:0]               div_den;
  logic [SIDE_W-1:0]               side_val;
  logic                            res_kind_r, res_last_r;
  logic [rrcm_pkg::POS_W-1:0]      res_pos_r;
  logic [rrcm_pkg::MEAN_W-1:0]     res_mean_r;

  // saturate side registers to 1..MAX_SIDE
  always_comb begin
    if (cfg_data == '0) begin
      side_val = SIDE_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_SIDE)) begin
      side_val = SIDE_W'(MAX_SIDE);
    end else begin
      side_val = SIDE_W'(cfg_data);
    end
  end

  // keep counts inside the region
  assign col_idx  = (SIDE_W'(col_cnt_r) >= width_r)  ? '0 : col_cnt_r;
  assign row_idx  = (SIDE_W'(row_cnt_r) >= height_r) ? '0 : row_cnt_r;
  assign last_row = (SIDE_W'(row_cnt_r) == height_r - SIDE_W'(1));
  assign last_col = (SIDE_W'(col_cnt_r) == width_r - SIDE_W'(1));

  // column sum update
  assign csum_nxt = (row_cnt_r == '0) ? SUM_W'(px_r) : rd_data_r + SUM_W'(px_r);

  // configuration and region counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= SIDE_W'(1);
      height_r    <= SIDE_W'(1);
      first_col_r <= '0;
      first_row_r <= '0;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      row_sum_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rrcm_pkg::REG_WIDTH:     width_r     <= side_val;
        rrcm_pkg::REG_HEIGHT:    height_r    <= side_val;
        rrcm_pkg::REG_FIRST_COL: first_col_r <= rrcm_pkg::OFFS_W'(cfg_data);
        rrcm_pkg::REG_FIRST_ROW: first_row_r <= rrcm_pkg::OFFS_W'(cfg_data);
        default: ;
      endcase
      if (cfg_idx == rrcm_pkg::REG_WIDTH || cfg_idx == rrcm_pkg::REG_HEIGHT ||
          cfg_idx == rrcm_pkg::REG_FIRST_COL || cfg_idx == rrcm_pkg::REG_FIRST_ROW) begin
        col_cnt_r <= '0;
        row_cnt_r <= '0;
        row_sum_r <= '0;
      end
    end else begin
      priority if (cmd.load) begin
        col_cnt_r <= col_idx;
        row_cnt_r <= row_idx;
      end else if (cmd.update) begin
        row_sum_r <= row_sum_r + SUM_W'(px_r);
      end else if (cmd.advance) begin
        if (last_col) begin
          row_sum_r <= '0;
          col_cnt_r <= '0;
          row_cnt_r <= last_row ? '0 : row_cnt_r + CNT_W'(1);
        end else begin
          col_cnt_r <= col_cnt_r + CNT_W'(1);
        end
      end else begin
      end
    end
  end

  // column sum memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data_r <= column_sums[col_idx];
    end
    if (cmd.update) begin
      column_sums[col_cnt_r] <= csum_nxt;
    end
  end

  // pixel and sum holding
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= pixel[PIXEL_BITS-1:0];
    end
    if (cmd.update) begin
      csum_r <= csum_nxt;
    end
    if (div_start) begin
      kind_r <= cmd.start_col;
    end
  end

  // shared divider
  assign div_start = cmd.start_col | cmd.start_row;
  assign div_num   = cmd.start_col ? csum_r : row_sum_r;
  assign div_den   = cmd.start_col ? height_r : width_r;

  rrcm_div #(
    .NUM_W (SUM_W),
    .DEN_W (SIDE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (div_done) begin
      res_kind_r <= kind_r;
      res_mean_r <= rrcm_pkg::MEAN_W'(div_quo);
      if (kind_r == rrcm_pkg::KIND_COL) begin
        res_pos_r  <= rrcm_pkg::POS_W'(first_col_r) + rrcm_pkg::POS_W'(col_cnt_r);
        res_last_r <= 1'b0;
      end else begin
        res_pos_r  <= rrcm_pkg::POS_W'(first_row_r) + rrcm_pkg::POS_W'(row_cnt_r);
        res_last_r <= last_row;
      end
    end
  end

  assign sts.last_row = last_row;
  assign sts.last_col = last_col;
  assign sts.div_done = div_done;

  assign res_kind     = res_kind_r;
  assign res_position = res_pos_r;
  assign res_mean     = res_mean_r;
  assign res_last     = res_last_r;

endmodule

// ===== hdl/rrcm_ctrl.sv =====
module rrcm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rrcm_pkg::sts_t sts,
  output rrcm_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_READ    = 7'b0000010,
    ST_CALC    = 7'b0000100,
    ST_DIV_COL = 7'b0001000,
    ST_OUT_COL = 7'b0010000,
    ST_DIV_ROW = 7'b0100000,
    ST_OUT_ROW = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CALC;
      end
      ST_CALC: begin
        priority if (sts.last_row) begin
          cmd.start_col = 1'b1;
          state_nxt     = ST_DIV_COL;
        end else if (sts.last_col) begin
          cmd.start_row = 1'b1;
          state_nxt     = ST_DIV_ROW;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_DIV_COL: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT_COL;
        end
      end
      ST_OUT_COL: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last_col) begin
            cmd.start_row = 1'b1;
            state_nxt     = ST_DIV_ROW;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_DIV_ROW: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT_ROW;
        end
      end
      ST_OUT_ROW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/region_row_column_mean.sv =====
// Row and column means of an image region. Pixels arrive in raster order; each pixel goes
// through accept, column sum memory read-modify-write and decision. A pixel that ends a
// row, or any pixel of the last row, also runs the shared restoring divider once per mean,
// and each result then waits on out_ch.ready; the last pixel of a row in the last row runs
// it twice. The input is not ready again until every result of the current pixel has been
// taken. Any register write restarts the region; writes are taken in any cycle but belong
// in idle time.
module region_row_column_mean #(
  parameter int MAX_SIDE   = rrcm_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS = rrcm_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rrcm_in_if.sink     in_ch,
  rrcm_out_if.source  out_ch,
  rrcm_cfg_if.sink    cfg_ch
);

  rrcm_pkg::cmd_t cmd;
  rrcm_pkg::sts_t sts;

  // configuration is always taken
  assign cfg_ch.ready = 1'b1;

  // sequencing
  rrcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // sums, memory, divider and result register
  rrcm_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_ch.valid),
    .cfg_idx      (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .pixel        (in_ch.pixel),
    .cmd          (cmd),
    .sts          (sts),
    .res_kind     (out_ch.kind),
    .res_position (out_ch.position),
    .res_mean     (out_ch.mean),
    .res_last     (out_ch.last)
  );

endmodule

// ===== hdl/rrcm_checker.sv =====
module rrcm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_kind,
  input logic [rrcm_pkg::POS_W-1:0]       out_position,
  input logic [rrcm_pkg::MEAN_W-1:0]      out_mean,
  input logic                             out_last
);

  // a stalled result keeps its request up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_position) &&
                                $stable(out_mean) && $stable(out_last))
    else $error("result payload changed while stalled");

  // one pixel at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted request");

  // no new pixel while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // the region closes with a row mean
  a_last_is_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == rrcm_pkg::KIND_ROW)
    else $error("final result is not a row mean");

endmodule

bind region_row_column_mean rrcm_checker u_rrcm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_position (out_ch.position),
  .out_mean     (out_ch.mean),
  .out_last     (out_ch.last)
);
